/* design/ilar_pkg.sv */
`default_nettype none

package ilar_pkg;

    // List geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int SLOT_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Fixed field widths of the stream payloads
    localparam int ENTRY_W = 32;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

    // Request opcodes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [DATA_WIDTH-1:0] word_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_WALK,
        ST_UNLINK,
        ST_FREE,
        ST_DONE
    } state_t;

    // Store access from the sequencer: one read and one write per store each cycle
    typedef struct packed {
        slot_t link_raddr;
        logic  link_we;
        slot_t link_waddr;
        slot_t link_wdata;
        slot_t entry_raddr;
        logic  entry_we;
        slot_t entry_waddr;
        word_t entry_wdata;
    } store_req_t;

endpackage

`default_nettype wire

/* design/ilar_store.sv */
`default_nettype none

module ilar_store (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ilar_pkg::store_req_t req,
    output      ilar_pkg::slot_t    link_rdata,
    output      ilar_pkg::word_t    entry_rdata
);
    import ilar_pkg::*;

    slot_t link_reg  [DEPTH];
    word_t entry_reg [DEPTH];
    slot_t link_rdata_reg;
    word_t entry_rdata_reg;

    // Link store: reset chains every slot to the next as the free list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                link_reg[i] <= (i + 1 < DEPTH) ? SLOT_W'(i + 1) : '0;
            end
        end else if (req.link_we) begin
            link_reg[req.link_waddr] <= req.link_wdata;
        end
    end

    // Entry store: contents only read after written, no reset
    always_ff @(posedge aclk) begin
        if (req.entry_we) begin
            entry_reg[req.entry_waddr] <= req.entry_wdata;
        end
    end

    // Registered reads; the address is presented in the cycle before its data is used
    always_ff @(posedge aclk) begin
        link_rdata_reg  <= link_reg[req.link_raddr];
        entry_rdata_reg <= entry_reg[req.entry_raddr];
    end

    assign link_rdata  = link_rdata_reg;
    assign entry_rdata = entry_rdata_reg;

endmodule

`default_nettype wire

/* design/ilar_ctrl.sv */
`default_nettype none

module ilar_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // request side
    input  wire logic                 in_valid,
    output      logic                 in_ready,
    input  wire logic                 in_op,
    input  wire logic [ilar_pkg::ENTRY_W-1:0] in_data,
    input  wire logic [ilar_pkg::POS_W-1:0]   in_pos,
    // result side
    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output      logic [ilar_pkg::ENTRY_W-1:0] out_removed,
    output      logic                 out_found,
    output      logic                 out_accepted,
    output      logic [ilar_pkg::COUNT_W-1:0] out_count,
    // store access
    output      ilar_pkg::store_req_t req,
    input  wire ilar_pkg::slot_t      link_rdata,
    input  wire ilar_pkg::word_t      entry_rdata
);
    import ilar_pkg::*;

    state_t            state_reg, state_next;
    word_t             data_reg, data_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  step_reg, step_next;
    slot_t             head_reg, head_next;
    slot_t             tail_reg, tail_next;
    slot_t             free_reg, free_next;
    slot_t             cur_reg, cur_next;
    slot_t             prev_reg, prev_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    word_t             rem_reg, rem_next;
    logic              found_reg, found_next;
    logic              acc_reg, acc_next;
    logic              ovalid_reg, ovalid_next;
    logic [ENTRY_W-1:0] orem_reg, orem_next;
    logic              ofound_reg, ofound_next;
    logic              oacc_reg, oacc_next;
    logic [COUNT_W-1:0] ocount_reg, ocount_next;

    logic accept;
    logic pos_hit;
    logic pos_is_last;
    logic step_more;
    logic out_free;

    assign accept      = in_valid && in_ready;
    assign pos_hit     = CMP_W'(in_pos) < CMP_W'(count_reg);
    assign pos_is_last = (CMP_W'(pos_reg) + CMP_W'(1)) == CMP_W'(count_reg);
    assign step_more   = step_reg < pos_reg;
    assign out_free    = !ovalid_reg || out_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_op == OP_APPEND) begin
                        state_next = ST_APPEND;
                    end else if (pos_hit) begin
                        state_next = ST_WALK;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_APPEND: state_next = ST_DONE;
            ST_WALK: begin
                if (!step_more) begin
                    state_next = ST_UNLINK;
                end
            end
            ST_UNLINK: state_next = ST_FREE;
            ST_FREE:   state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and store access per state
    always_comb begin
        data_next   = data_reg;
        pos_next    = pos_reg;
        step_next   = step_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        free_next   = free_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        count_next  = count_reg;
        rem_next    = rem_reg;
        found_next  = found_reg;
        acc_next    = acc_reg;
        ovalid_next = ovalid_reg && !out_ready;
        orem_next   = orem_reg;
        ofound_next = ofound_reg;
        oacc_next   = oacc_reg;
        ocount_next = ocount_reg;
        in_ready    = 1'b0;
        req         = '0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (accept) begin
                    data_next  = DATA_WIDTH'(in_data);
                    pos_next   = in_pos;
                    step_next  = '0;
                    cur_next   = head_reg;
                    prev_next  = '0;
                    rem_next   = '0;
                    found_next = 1'b0;
                    acc_next   = 1'b0;
                end
            end
            ST_APPEND: begin
                // If the list is not full, take the free-list head, link it behind the tail
                if (count_reg < CNT_W'(DEPTH)) begin
                    free_next         = link_rdata;
                    req.entry_we      = 1'b1;
                    req.entry_waddr   = free_reg;
                    req.entry_wdata   = data_reg;
                    if (count_reg == '0) begin
                        head_next = free_reg;
                    end else begin
                        req.link_we    = 1'b1;
                        req.link_waddr = tail_reg;
                        req.link_wdata = free_reg;
                    end
                    tail_next  = free_reg;
                    count_next = count_reg + CNT_W'(1);
                    acc_next   = 1'b1;
                end
            end
            ST_WALK: begin
                // One link hop per cycle
                if (step_more) begin
                    prev_next = cur_reg;
                    cur_next  = link_rdata;
                    step_next = step_reg + POS_W'(1);
                end
            end
            ST_UNLINK: begin
                rem_next   = entry_rdata;
                found_next = 1'b1;
                if (pos_reg == '0) begin
                    head_next = link_rdata;
                end else begin
                    req.link_we    = 1'b1;
                    req.link_waddr = prev_reg;
                    req.link_wdata = link_rdata;
                end
                if (pos_is_last) begin
                    tail_next = (pos_reg == '0) ? '0 : prev_reg;
                end
            end
            ST_FREE: begin
                // Return the slot to the free list
                req.link_we    = 1'b1;
                req.link_waddr = cur_reg;
                req.link_wdata = free_reg;
                free_next      = cur_reg;
                count_next     = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1)) begin
                    head_next = '0;
                    tail_next = '0;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    orem_next   = ENTRY_W'(rem_reg);
                    ofound_next = found_reg;
                    oacc_next   = acc_reg;
                    ocount_next = COUNT_W'(count_reg);
                end
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase

        // Read addresses for the coming cycle; the stores return registered data
        req.link_raddr  = (state_next == ST_APPEND) ? free_reg : cur_next;
        req.entry_raddr = cur_next;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            free_reg   <= '0;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            free_reg   <= free_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        data_reg   <= data_next;
        pos_reg    <= pos_next;
        step_reg   <= step_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        rem_reg    <= rem_next;
        found_reg  <= found_next;
        acc_reg    <= acc_next;
        orem_reg   <= orem_next;
        ofound_reg <= ofound_next;
        oacc_reg   <= oacc_next;
        ocount_reg <= ocount_next;
    end

    assign out_valid    = ovalid_reg;
    assign out_removed  = orem_reg;
    assign out_found    = ofound_reg;
    assign out_accepted = oacc_reg;
    assign out_count    = ocount_reg;

endmodule

`default_nettype wire

/* design/indexed_list_append_remove_top.sv */
`default_nettype none

// Channel  | Dir | tdata (low bit up)                       | tuser
// s_       | in  | entry_data[31:0], position[35:32], 0 pad  | op (0 append, 1 remove)
// m_       | out | removed_data[31:0], count_after[36:32], 0 | found[0], accepted[1]
//
// One request at a time; s_tready is high only while the sequencer idles.
// Append links a free slot behind the tail. Remove at position p walks the links
// from the head, one per cycle, then unlinks and frees the slot; a miss skips it.
// A result waits in the output register while m_tready is low; the next request
// is still taken and runs until its own result needs that register.
// aresetn is synchronous; it empties the list and chains all slots as free.

module indexed_list_append_remove_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [39:0] s_tdata,  // entry_data[31:0], position[35:32], zeros
    input  wire logic        s_tuser,  // op
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [39:0] m_tdata,  // removed_data[31:0], count_after[36:32], zeros
    output      logic [1:0]  m_tuser   // found[0], accepted[1]
);
    import ilar_pkg::*;

    store_req_t          req;
    slot_t               link_rdata;
    word_t               entry_rdata;
    logic [ENTRY_W-1:0]  removed;
    logic                found;
    logic                accepted;
    logic [COUNT_W-1:0]  count_after;

    // Sequencer
    ilar_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_op        (s_tuser),
        .in_data      (s_tdata[31:0]),
        .in_pos       (s_tdata[35:32]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_removed  (removed),
        .out_found    (found),
        .out_accepted (accepted),
        .out_count    (count_after),
        .req          (req),
        .link_rdata   (link_rdata),
        .entry_rdata  (entry_rdata)
    );

    // Entry and link stores
    ilar_store u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req         (req),
        .link_rdata  (link_rdata),
        .entry_rdata (entry_rdata)
    );

    // Result packing
    assign m_tdata = {3'b000, count_after, removed};
    assign m_tuser = {accepted, found};

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
    import ilar_pkg::*;

    localparam int QUIET_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 40;
    localparam int RANDOM_PER_PHASE = 242;

    // One result as the block reports it
    typedef struct packed {
        logic [31:0] removed_data;
        logic        found;
        logic        accepted;
        logic [4:0]  count_after;
    } list_result_t;

    // One directed request; want is used only where typed is set
    typedef struct packed {
        logic         op;
        logic [31:0]  data;
        logic [3:0]   pos;
        logic         typed;
        list_result_t want;
    } list_request_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    int send_idle_pct  = 32;
    int recv_stall_pct = 69;
    int error_count    = 0;
    int result_index   = 0;
    int quiet_cycles   = 0;

    // Mirror of the list contents, head first
    logic [31:0]  list_words[$];
    list_result_t expected_results[$];
    list_result_t seen_result;
    list_result_t oldest_result;

    // Directed requests: empty list, fill to full, overflow, head/middle/tail removes, miss
    list_request_row_t directed_rows [24] = '{
        '{OP_REMOVE, 32'hFFFF_FFFF, 4'd0,  1'b1, '{32'h0, 1'b0, 1'b0, 5'd0}},
        '{OP_REMOVE, 32'h0,         4'd15, 1'b1, '{32'h0, 1'b0, 1'b0, 5'd0}},
        '{OP_APPEND, 32'h0000_0000, 4'd15, 1'b1, '{32'h0, 1'b0, 1'b1, 5'd1}},
        '{OP_APPEND, 32'hFFFF_FFFF, 4'd0,  1'b1, '{32'h0, 1'b0, 1'b1, 5'd2}},
        '{OP_APPEND, 32'h0000_0001, 4'd0,  1'b0, '0},
        '{OP_APPEND, 32'h8000_0000, 4'd0,  1'b0, '0},
        '{OP_APPEND, 32'h1234_5678, 4'd0,  1'b0, '0},
        '{OP_APPEND, 32'hDEAD_BEEF, 4'd0,  1'b0, '0},
        '{OP_APPEND, 32'h5555_5555, 4'd0,  1'b0, '0},
        '{OP_APPEND, 32'hAAAA_AAAA, 4'd0,  1'b0, '0},
        '{OP_APPEND, 32'h0F0F_0F0F, 4'd0,  1'b0, '0},
        '{OP_APPEND, 32'hF0F0_F0F0, 4'd0,  1'b0, '0},
        '{OP_APPEND, 32'h0000_FFFF, 4'd0,  1'b0, '0},
        '{OP_APPEND, 32'hFFFF_0000, 4'd0,  1'b0, '0},
        '{OP_APPEND, 32'h7FFF_FFFF, 4'd0,  1'b0, '0},
        '{OP_APPEND, 32'hC001_D00D, 4'd0,  1'b0, '0},
        '{OP_APPEND, 32'h0BAD_F00D, 4'd0,  1'b0, '0},
        '{OP_APPEND, 32'h3C3C_C3C3, 4'd0,  1'b0, '0},
        '{OP_APPEND, 32'h1357_9BDF, 4'd15, 1'b1, '{32'h0, 1'b0, 1'b0, 5'd16}},
        '{OP_REMOVE, 32'h0,         4'd15, 1'b0, '0},
        '{OP_REMOVE, 32'hFFFF_FFFF, 4'd0,  1'b1, '{32'h0, 1'b1, 1'b0, 5'd14}},
        '{OP_REMOVE, 32'h0,         4'd7,  1'b0, '0},
        '{OP_REMOVE, 32'h0,         4'd13, 1'b1, '{32'h0, 1'b0, 1'b0, 5'd13}},
        '{OP_REMOVE, 32'h0,         4'd0,  1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0, 5'd12}}
    };

    indexed_list_append_remove_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic flag_mismatch(input string msg);
        $display("tb: mismatch on result %0d: %s", result_index, msg);
        error_count++;
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s got %h expected %h", field, got, want));
        end
    endtask

    // Apply one request to the mirrored list and return what the block should report
    function automatic list_result_t apply_list_op(input logic op, input logic [31:0] data,
                                                   input logic [3:0] pos);
        list_result_t res;
        res = '0;
        if (op == OP_APPEND) begin
            if (list_words.size() < DEPTH) begin
                list_words.push_back(data);
                res.accepted = 1'b1;
            end
        end else if (pos < list_words.size()) begin
            res.removed_data = list_words[pos];
            res.found        = 1'b1;
            list_words.delete(pos);
        end
        res.count_after = 5'(list_words.size());
        return res;
    endfunction

    // Present one request at the falling edge, hold it until taken
    task automatic send_request(input logic op, input logic [31:0] data, input logic [3:0] pos,
                                input logic typed, input list_result_t want);
        list_result_t modeled;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, pos, data};
        do @(posedge aclk); while (!s_tready);
        modeled = apply_list_op(op, data, pos);
        expected_results.push_back(typed ? want : modeled);
        @(negedge aclk);
    endtask

    // Result side back-pressure
    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_result.removed_data = m_tdata[31:0];
            seen_result.count_after  = m_tdata[36:32];
            seen_result.found        = m_tuser[0];
            seen_result.accepted     = m_tuser[1];
            if (expected_results.size() == 0) begin
                flag_mismatch("result with no request outstanding");
            end else begin
                oldest_result = expected_results.pop_front();
                check_field("removed_data", seen_result.removed_data,
                            oldest_result.removed_data);
                check_field("found", 32'(seen_result.found), 32'(oldest_result.found));
                check_field("accepted", 32'(seen_result.accepted),
                            32'(oldest_result.accepted));
                check_field("count_after", 32'(seen_result.count_after),
                            32'(oldest_result.count_after));
            end
            result_index++;
        end
    end

    // Watchdog: too long without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int          draw_index;
        int          append_pct;
        logic        op;
        logic [31:0] data;
        logic [3:0]  pos;

        s_tvalid   = 1'b0;
        s_tuser    = 1'b0;
        s_tdata    = '0;
        aresetn    = 1'b0;
        draw_index = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].op, directed_rows[i].data, directed_rows[i].pos,
                         directed_rows[i].typed, directed_rows[i].want);
        end

        // Random requests; three idling profiles
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct  = (phase == 0) ? 32 : (phase == 1) ? 69 : 0;
            recv_stall_pct = (phase == 0) ? 69 : (phase == 1) ? 32 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // alternate stretches that fill the list and stretches that drain it
                append_pct = ((draw_index / 40) % 2 == 0) ? 75 : 30;
                draw_index++;
                op   = ($urandom_range(99) < append_pct) ? OP_APPEND : OP_REMOVE;
                data = $urandom;
                if (list_words.size() > 0 && $urandom_range(99) < 85) begin
                    pos = 4'($urandom_range(list_words.size() - 1, 0));
                end else begin
                    pos = 4'($urandom_range(15, 0));
                end
                send_request(op, data, pos, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
